[hdl/pip_pkg.sv]
// Package of shared constants, types and codes for the point-in-polygon test core.
`default_nettype none
package pip_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int COORD_BITS   = 16;
  localparam int CFG_W        = 5;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int SAT_W        = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int DIFF_W       = COORD_BITS + 1;
  localparam int PROD_W       = 2 * DIFF_W;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_FINISH
  } pip_state_t;

  typedef struct packed {
    logic              load_query;
    logic              wr_en;
    logic              rd_en;
    logic              rd_first;
    logic [ADDR_W-1:0] rd_addr;
    logic              out_load;
  } pip_cmd_t;

  typedef struct packed {
    logic out_free;
    logic pipe_busy;
  } pip_status_t;

endpackage
`default_nettype wire

[hdl/pip_ctrl.sv]
// Controller state machine: request decode, edge walk sequencing and result hand-off.
`default_nettype none
module pip_ctrl
  import pip_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             req_type,
  input  wire logic             cfg_wr_en,
  input  wire logic [CFG_W-1:0] cfg_wr_data,
  input  wire pip_status_t      st,
  output logic                  in_stall,
  output pip_cmd_t              cmd
);

  pip_state_t       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [CFG_W-1:0] vertex_count;
  logic [CNT_W-1:0] n_sat;
  logic [CNT_W-1:0] addr_full;

  // Counts above the table size are clamped to the table size.
  assign n_sat = (SAT_W'(vertex_count) > SAT_W'(MAX_VERTICES)) ?
                 CNT_W'(MAX_VERTICES) : CNT_W'(vertex_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      vertex_count <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cfg_wr_en) begin
        vertex_count <= cfg_wr_data;
      end
    end
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    in_stall       = 1'b1;
    cmd            = '0;
    addr_full      = (cnt == '0) ? (n_sat - CNT_W'(1)) : (cnt - CNT_W'(1));
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (req_type == REQ_WRITE) begin
            cmd.wr_en = 1'b1;
          end else begin
            cmd.load_query = 1'b1;
            cnt_next       = '0;
            state_next     = (n_sat == '0) ? ST_FINISH : ST_WALK;
          end
        end
      end
      ST_WALK: begin
        // The first read fetches the closing vertex; each later read forms one edge.
        cmd.rd_en    = 1'b1;
        cmd.rd_first = (cnt == '0);
        cmd.rd_addr  = addr_full[ADDR_W-1:0];
        cnt_next     = cnt + CNT_W'(1);
        if (cnt == n_sat) begin
          state_next = ST_DRAIN1;
        end
      end
      ST_DRAIN1: begin
        state_next = ST_DRAIN2;
      end
      ST_DRAIN2: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[hdl/pip_datapath.sv]
// Datapath: vertex memory, three-stage edge crossing pipeline and result register.
`default_nettype none
module pip_datapath
  import pip_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire pip_cmd_t                     cmd,
  input  wire logic        [ADDR_W-1:0]     vertex_index,
  input  wire logic signed [COORD_BITS-1:0] vertex_x,
  input  wire logic signed [COORD_BITS-1:0] vertex_y,
  input  wire logic signed [COORD_BITS-1:0] point_x,
  input  wire logic signed [COORD_BITS-1:0] point_y,
  input  wire logic                         out_stall,
  output logic                              out_valid,
  output logic                              inside_res,
  output pip_status_t                       st
);

  logic signed [COORD_BITS-1:0] mem_x [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] mem_y [MAX_VERTICES];

  logic signed [COORD_BITS-1:0] px, py;
  logic signed [COORD_BITS-1:0] cur_x, cur_y, prev_x, prev_y;
  logic                         s1_edge, s2_edge;
  logic signed [PROD_W-1:0]     prod_l, prod_r;
  logic                         dy_neg;
  logic                         flag;

  logic signed [DIFF_W-1:0]     diff_a, diff_c, diff_d, diff_dy;
  logic                         straddle;
  logic                         toggle;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_x[vertex_index] <= vertex_x;
      mem_y[vertex_index] <= vertex_y;
    end
    if (cmd.rd_en) begin
      cur_x  <= mem_x[cmd.rd_addr];
      cur_y  <= mem_y[cmd.rd_addr];
      prev_x <= cur_x;
      prev_y <= cur_y;
    end
    if (cmd.load_query) begin
      px <= point_x;
      py <= point_y;
    end
  end

  // Edge runs from the current vertex i to the previous vertex j.
  always_comb begin
    diff_a   = DIFF_W'(px) - DIFF_W'(cur_x);
    diff_c   = DIFF_W'(prev_x) - DIFF_W'(cur_x);
    diff_d   = DIFF_W'(py) - DIFF_W'(cur_y);
    diff_dy  = DIFF_W'(prev_y) - DIFF_W'(cur_y);
    straddle = (cur_y > py) != (prev_y > py);
  end

  always_ff @(posedge clk) begin
    prod_l <= diff_a * diff_dy;
    prod_r <= diff_c * diff_d;
    dy_neg <= diff_dy[DIFF_W-1];
  end

  // The point is left of the crossing when the product order agrees with the sign of dy.
  assign toggle = dy_neg ? (prod_l > prod_r) : (prod_l < prod_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_edge   <= 1'b0;
      s2_edge   <= 1'b0;
      flag      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_edge <= cmd.rd_en && !cmd.rd_first;
      s2_edge <= s1_edge && straddle;
      if (cmd.load_query) begin
        flag <= 1'b0;
      end else if (s2_edge && toggle) begin
        flag <= !flag;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      inside_res <= flag;
    end
  end

  assign st.out_free  = !out_valid || !out_stall;
  assign st.pipe_busy = s1_edge || s2_edge;

endmodule
`default_nettype wire

[hdl/point_in_polygon_test_core.sv]
// Top level of the point-in-polygon test core: controller, datapath and checks.
`default_nettype none
// Usage:
// One input channel carries requests (in_valid / in_stall). A request with
// req_type 0 stores vertex_x / vertex_y in slot vertex_index and gives no
// result. A request with req_type 1 tests point_x /
// point_y against the polygon of the first vertex_count slots by the
// even-odd rule and returns one inside_res on the output channel
// (out_valid / out_stall).
// A query with N vertices (count clamped to 16) makes N + 1 single-port vertex
// reads (closing vertex first); the last edge then passes the multiply and
// compare stages, and the controller loads the output register, which raises
// out_valid. The next request is taken after that load, so a query holds the
// input until its result is loaded. Zero vertices answer 0 with no reads.
// Requests are taken only while the controller is idle; one query is in
// flight at a time. The result sits in an output register, so a new request
// is taken while a previous result still waits; a finished query waits if
// the output register is still stalled.
// vertex_count is written through cfg_wr_en / cfg_wr_data; the user must write it
// only while idle, which the block does not enforce. Reset clears the controller,
// the count and the output valid; vertex slots hold nothing defined until written.
module point_in_polygon_test_core
  import pip_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         req_type,
  input  wire logic        [ADDR_W-1:0]     vertex_index,
  input  wire logic signed [COORD_BITS-1:0] vertex_x,
  input  wire logic signed [COORD_BITS-1:0] vertex_y,
  input  wire logic signed [COORD_BITS-1:0] point_x,
  input  wire logic signed [COORD_BITS-1:0] point_y,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              inside_res,
  input  wire logic                         cfg_wr_en,
  input  wire logic        [CFG_W-1:0]      cfg_wr_data
);

  pip_cmd_t    cmd;
  pip_status_t st;

  pip_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .req_type   (req_type),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .st         (st),
    .in_stall   (in_stall),
    .cmd        (cmd)
  );

  pip_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .vertex_index(vertex_index),
    .vertex_x    (vertex_x),
    .vertex_y    (vertex_y),
    .point_x     (point_x),
    .point_y     (point_y),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .inside_res  (inside_res),
    .st          (st)
  );

  // A result is never loaded over one that is still waiting to be taken.
  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> st.out_free)
    else $error("result loaded while output register stalled");

  // When the block takes a request, no edge of an earlier query is still in flight.
  a_pipe_empty_on_accept : assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !st.pipe_busy)
    else $error("edge pipeline busy while accepting requests");

  // A new result appears on the output only after the controller loaded it.
  a_valid_from_load : assert property (@(posedge clk) disable iff (rst)
    !out_valid ##1 out_valid |-> $past(cmd.out_load))
    else $error("out_valid rose without a result load");

  // Memory reads and request acceptance never overlap.
  a_no_read_when_idle : assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> in_stall)
    else $error("vertex read while accepting requests");

endmodule
`default_nettype wire
